// File: rtl/core/asymmetric_garch_variance_filter_unit_macros.svh
// Assertion macros used by the checker file of the variance filter.
// Needs nothing but the simulator's assertion support.
`ifndef ASYMMETRIC_GARCH_VARIANCE_FILTER_UNIT_MACROS_SVH
`define ASYMMETRIC_GARCH_VARIANCE_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AGVF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("variance filter check failed");

// Next-cycle implication, disabled while reset is asserted.
`define AGVF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("variance filter check failed");

`endif

// File: rtl/core/agvf_pkg.sv
// Shared widths, codes and sequencer states of the variance filter.
// No dependencies; the interfaces, the top level and the checker refer to it by scoped names.
package agvf_pkg;

	localparam int ARCH_TAPS  = 2;
	localparam int GARCH_TAPS = 2;
	localparam int FRAC_BITS  = 16;
	localparam int DEPTH      = 4;

	localparam int VAL_W      = 32;
	localparam int VAR_W      = 31;
	localparam int COEF_W     = 16;
	localparam int COEF_BUS_W = COEF_W * DEPTH;
	localparam int WARM_W     = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam int NTAPS  = ARCH_TAPS + GARCH_TAPS;
	localparam int TAP_W  = $clog2(NTAPS + 1);
	localparam int IDX_W  = $clog2(DEPTH);

	localparam int MUL_W  = 32;
	localparam int PROD_W = 2 * MUL_W;
	localparam int G2_W   = PROD_W - FRAC_BITS;
	localparam int D_W    = G2_W + 2;
	localparam int ACC_W  = VAL_W + COEF_W + 4;
	localparam int RAD_W  = ((VAR_W + FRAC_BITS + 1) / 2) * 2;
	localparam int WS_W   = PROD_W + MUL_W - FRAC_BITS + 1;

	localparam logic [VAR_W-1:0] VAR_MAX = '1;

	localparam logic MODE_AGARCH  = 1'b0;
	localparam logic MODE_NAGARCH = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OMEGA,
		REG_ARCH_COEFS,
		REG_GARCH_COEFS,
		REG_ASYM_SHIFT,
		REG_BACK_CAST,
		REG_MODE,
		REG_WARMUP_LEN
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GSQ,
		ST_WLO,
		ST_WHI,
		ST_WFIN,
		ST_TAP,
		ST_VAR,
		ST_SQRT,
		ST_SCALE,
		ST_DIFF,
		ST_SQUARE,
		ST_SHOCK,
		ST_FIN
	} state_t;

endpackage

// File: rtl/core/agvf_if.sv
// Handshake channel interfaces of the variance filter: samples, results, configuration.
// Depends on agvf_pkg for the field widths.
interface agvf_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [agvf_pkg::VAL_W-1:0]    sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface agvf_out_if;
	logic                          valid;
	logic                          ready;
	logic [agvf_pkg::VAR_W-1:0]    variance;
	logic                          saturated;

	modport source (output valid, output variance, output saturated, input ready);
	modport sink (input valid, input variance, input saturated, output ready);
endinterface

interface agvf_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [agvf_pkg::CFG_IDX_W-1:0]     index;
	logic [agvf_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/asymmetric_garch_variance_filter_unit.sv
// Top level of the asymmetric GARCH (AGARCH / NAGARCH) conditional variance filter.
// Depends on agvf_pkg and the channel interfaces in agvf_if.sv.

// Each sample item yields one result item holding the conditional variance in unsigned
// Q15.16 and a flag that tells whether the variance or the new shock was clamped at zero or
// saturated. The block works on one item at a time: it takes a sample only when its
// sequencer is idle, and all arithmetic goes through one shared 32x32 multiplier whose
// product is registered. An item during warmup goes through gamma squared, the low and
// high back_cast multiplies and the warmup result. After warmup an AGARCH item runs the
// tap loop over ARCH_TAPS + GARCH_TAPS taps, one multiply-accumulate per cycle, then the
// variance, the square and the shock. A NAGARCH item adds a square root of the variance,
// found one result bit per cycle, followed by a scaling multiply and a subtract. The
// finished result sits in an output register, so a new sample is taken while the previous
// result still waits downstream; the sequencer holds in its last state only when it
// finishes another item before that result is taken.
// Configuration writes are always accepted and must only be issued while the block is idle.
// The shock and variance histories and the item counter clear on reset.
module asymmetric_garch_variance_filter_unit (
	input logic         clk,
	input logic         arst_n,
	agvf_cfg_if.sink    cfg_ch,
	agvf_in_if.sink     sample_ch,
	agvf_out_if.source  result_ch
);

	localparam int FB     = agvf_pkg::FRAC_BITS;
	localparam int VAL_W  = agvf_pkg::VAL_W;
	localparam int VAR_W  = agvf_pkg::VAR_W;
	localparam int COEF_W = agvf_pkg::COEF_W;
	localparam int MUL_W  = agvf_pkg::MUL_W;
	localparam int PROD_W = agvf_pkg::PROD_W;
	localparam int G2_W   = agvf_pkg::G2_W;
	localparam int D_W    = agvf_pkg::D_W;
	localparam int ACC_W  = agvf_pkg::ACC_W;
	localparam int RAD_W  = agvf_pkg::RAD_W;
	localparam int WS_W   = agvf_pkg::WS_W;
	localparam int S0_W   = G2_W + 2;
	localparam int DEPTH  = agvf_pkg::DEPTH;
	localparam int NTAPS  = agvf_pkg::NTAPS;
	localparam int TAP_W  = agvf_pkg::TAP_W;
	localparam int IDX_W  = agvf_pkg::IDX_W;

	// Configuration registers.
	logic signed [VAL_W-1:0]               omega_q;
	logic [agvf_pkg::COEF_BUS_W-1:0]       arch_q;
	logic [agvf_pkg::COEF_BUS_W-1:0]       garch_q;
	logic signed [VAL_W-1:0]               gamma_q;
	logic signed [VAL_W-1:0]               bc_q;
	logic                                  mode_q;
	logic [agvf_pkg::WARM_W-1:0]           warm_len_q;

	// Filter state.
	logic [VAR_W-1:0]                      sh_q [DEPTH];
	logic [VAR_W-1:0]                      vh_q [DEPTH];
	logic [agvf_pkg::WARM_W-1:0]           item_cnt_q;

	// Sequencer and working registers.
	agvf_pkg::state_t                      state_q;
	agvf_pkg::state_t                      next_state;
	logic [TAP_W-1:0]                      tap_q;
	logic                                  warm_q;
	logic signed [VAL_W-1:0]               sample_q;
	logic [PROD_W-1:0]                     prod_q;
	logic [PROD_W-1:0]                     plo_q;
	logic [G2_W-1:0]                       g2_q;
	logic signed [ACC_W-1:0]               acc_q;
	logic [RAD_W-1:0]                      x_q;
	logic [RAD_W-1:0]                      root_q;
	logic [RAD_W-1:0]                      bit_q;
	logic signed [D_W-1:0]                 d_q;
	logic                                  big_q;
	logic [VAR_W-1:0]                      var_q;
	logic [VAR_W-1:0]                      shk_q;
	logic                                  flag_q;

	// Output register.
	logic                                  out_valid_q;
	logic [VAR_W-1:0]                      out_var_q;
	logic                                  out_sat_q;

	// Combinational signals.
	logic [MUL_W-1:0]                      gmag;
	logic [MUL_W-1:0]                      mul_a;
	logic [MUL_W-1:0]                      mul_b;
	logic [IDX_W-1:0]                      arch_idx;
	logic [IDX_W-1:0]                      garch_idx;
	logic                                  accept;
	logic                                  fin_fire;

	logic signed [S0_W-1:0]                sum0;
	logic [WS_W-1:0]                       sum1;
	logic [VAR_W-1:0]                      warm_var;
	logic [VAR_W-1:0]                      warm_shk;
	logic                                  warm_flag;

	logic [VAR_W-1:0]                      acc_var;
	logic                                  acc_flag;

	logic [RAD_W:0]                        trial;
	logic [D_W-1:0]                        tx;
	logic signed [D_W-1:0]                 sample_x;
	logic [D_W-1:0]                        dmag;
	logic [G2_W-1:0]                       sq;
	logic [VAR_W-1:0]                      sq_shk;
	logic                                  sq_flag;

	assign accept       = sample_ch.valid && sample_ch.ready;
	assign fin_fire     = (state_q == agvf_pkg::ST_FIN) && (!out_valid_q || result_ch.ready);
	assign cfg_ch.ready = 1'b1;

	// Magnitude of gamma; the most negative gamma gives 2^31, which still fits 32 bits.
	assign gmag = gamma_q[VAL_W-1] ? (~gamma_q + 1'b1) : gamma_q;

	assign arch_idx  = tap_q[IDX_W-1:0];
	assign garch_idx = IDX_W'(tap_q - TAP_W'(agvf_pkg::ARCH_TAPS));

	//------------------------------------------------------------------
	// Sequencer: next state.
	//------------------------------------------------------------------
	always_comb begin
		next_state = state_q;
		unique case (state_q)
			agvf_pkg::ST_IDLE: begin
				if (sample_ch.valid) next_state = agvf_pkg::ST_GSQ;
			end
			agvf_pkg::ST_GSQ: begin
				next_state = warm_q ? agvf_pkg::ST_WLO : agvf_pkg::ST_TAP;
			end
			agvf_pkg::ST_WLO:  next_state = agvf_pkg::ST_WHI;
			agvf_pkg::ST_WHI:  next_state = agvf_pkg::ST_WFIN;
			agvf_pkg::ST_WFIN: next_state = agvf_pkg::ST_FIN;
			agvf_pkg::ST_TAP: begin
				if (tap_q == TAP_W'(NTAPS)) next_state = agvf_pkg::ST_VAR;
			end
			agvf_pkg::ST_VAR: begin
				next_state = (mode_q == agvf_pkg::MODE_NAGARCH) ?
					agvf_pkg::ST_SQRT : agvf_pkg::ST_SQUARE;
			end
			agvf_pkg::ST_SQRT: begin
				if (bit_q[0]) next_state = agvf_pkg::ST_SCALE;
			end
			agvf_pkg::ST_SCALE:  next_state = agvf_pkg::ST_DIFF;
			agvf_pkg::ST_DIFF:   next_state = agvf_pkg::ST_SQUARE;
			agvf_pkg::ST_SQUARE: next_state = agvf_pkg::ST_SHOCK;
			agvf_pkg::ST_SHOCK:  next_state = agvf_pkg::ST_FIN;
			agvf_pkg::ST_FIN: begin
				if (fin_fire) next_state = agvf_pkg::ST_IDLE;
			end
			default: next_state = agvf_pkg::ST_IDLE;
		endcase
	end

	//------------------------------------------------------------------
	// Sequencer outputs: ready and the operands of the shared multiplier.
	//------------------------------------------------------------------
	always_comb begin
		sample_ch.ready = 1'b0;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			agvf_pkg::ST_IDLE: sample_ch.ready = 1'b1;
			agvf_pkg::ST_GSQ: begin
				// gamma squared
				mul_a = gmag;
				mul_b = gmag;
			end
			agvf_pkg::ST_WLO: begin
				// back_cast times the low word of g2, which sits in the product register
				mul_a = MUL_W'(bc_q);
				mul_b = prod_q[FB +: MUL_W];
			end
			agvf_pkg::ST_WHI: begin
				mul_a = MUL_W'(bc_q);
				mul_b = MUL_W'(g2_q >> MUL_W);
			end
			agvf_pkg::ST_TAP: begin
				if (tap_q < TAP_W'(agvf_pkg::ARCH_TAPS)) begin
					mul_a = MUL_W'(arch_q[arch_idx*COEF_W +: COEF_W]);
					mul_b = MUL_W'(sh_q[arch_idx]);
				end else if (tap_q < TAP_W'(NTAPS)) begin
					mul_a = MUL_W'(garch_q[garch_idx*COEF_W +: COEF_W]);
					mul_b = MUL_W'(vh_q[garch_idx]);
				end
			end
			agvf_pkg::ST_SCALE: begin
				// |gamma| times the square root of the scaled variance
				mul_a = gmag;
				mul_b = MUL_W'(root_q);
			end
			agvf_pkg::ST_SQUARE: begin
				mul_a = dmag[MUL_W-1:0];
				mul_b = dmag[MUL_W-1:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	//------------------------------------------------------------------
	// Warmup results: variance is back_cast, shock is the seeded value.
	//------------------------------------------------------------------
	always_comb begin
		sum0 = {{(S0_W-VAL_W){bc_q[VAL_W-1]}}, bc_q} + {2'b00, g2_q};
		// (back_cast * (1 + g2)) >> FB = back_cast + ((hi << 32) + lo) >> FB
		sum1 = WS_W'(bc_q[VAR_W-1:0]) + (WS_W'(prod_q) << (MUL_W - FB)) + WS_W'(plo_q >> FB);
		warm_flag = 1'b0;
		if (bc_q[VAL_W-1]) begin
			warm_var  = '0;
			warm_flag = 1'b1;
		end else begin
			warm_var = bc_q[VAR_W-1:0];
		end
		if (mode_q == agvf_pkg::MODE_AGARCH) begin
			if (sum0[S0_W-1]) begin
				warm_shk  = '0;
				warm_flag = 1'b1;
			end else if (|sum0[S0_W-2:VAR_W]) begin
				warm_shk  = agvf_pkg::VAR_MAX;
				warm_flag = 1'b1;
			end else begin
				warm_shk = sum0[VAR_W-1:0];
			end
		end else if (bc_q[VAL_W-1] || bc_q == '0) begin
			// A back_cast that is not positive gives itself, clamped.
			warm_shk = '0;
		end else if (|sum1[WS_W-1:VAR_W]) begin
			warm_shk  = agvf_pkg::VAR_MAX;
			warm_flag = 1'b1;
		end else begin
			warm_shk = sum1[VAR_W-1:0];
		end
	end

	//------------------------------------------------------------------
	// Variance from the accumulator: drop the coefficient fraction, clamp.
	//------------------------------------------------------------------
	always_comb begin
		acc_flag = 1'b0;
		if (acc_q[ACC_W-1]) begin
			acc_var  = '0;
			acc_flag = 1'b1;
		end else if (|acc_q[ACC_W-2:COEF_W+VAR_W]) begin
			acc_var  = agvf_pkg::VAR_MAX;
			acc_flag = 1'b1;
		end else begin
			acc_var = acc_q[COEF_W +: VAR_W];
		end
	end

	//------------------------------------------------------------------
	// Shift difference, its magnitude, and the shock from its square.
	//------------------------------------------------------------------
	always_comb begin
		trial    = {1'b0, root_q} + {1'b0, bit_q};
		tx       = {2'b00, prod_q[PROD_W-1:FB]};
		sample_x = {{(D_W-VAL_W){sample_q[VAL_W-1]}}, sample_q};
		dmag     = d_q[D_W-1] ? D_W'(-d_q) : D_W'(d_q);
		sq       = prod_q[PROD_W-1:FB];
		sq_flag  = 1'b0;
		if (big_q || (|sq[G2_W-1:VAR_W])) begin
			sq_shk  = agvf_pkg::VAR_MAX;
			sq_flag = 1'b1;
		end else begin
			sq_shk = sq[VAR_W-1:0];
		end
	end

	//------------------------------------------------------------------
	// Control registers, configuration and filter state.
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= agvf_pkg::ST_IDLE;
			tap_q       <= '0;
			out_valid_q <= 1'b0;
			item_cnt_q  <= '0;
			omega_q     <= '0;
			arch_q      <= '0;
			garch_q     <= '0;
			gamma_q     <= '0;
			bc_q        <= '0;
			mode_q      <= agvf_pkg::MODE_AGARCH;
			warm_len_q  <= '0;
			for (int k = 0; k < DEPTH; k++) begin
				sh_q[k] <= '0;
				vh_q[k] <= '0;
			end
		end else begin
			state_q <= next_state;

			if (state_q == agvf_pkg::ST_TAP) begin
				tap_q <= tap_q + 1'b1;
			end else begin
				tap_q <= '0;
			end

			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			if (fin_fire) begin
				for (int k = DEPTH - 1; k > 0; k--) begin
					sh_q[k] <= sh_q[k-1];
					vh_q[k] <= vh_q[k-1];
				end
				sh_q[0] <= shk_q;
				vh_q[0] <= var_q;
				if (item_cnt_q != '1) item_cnt_q <= item_cnt_q + 1'b1;
			end

			if (cfg_ch.valid && cfg_ch.ready) begin
				unique case (agvf_pkg::cfg_reg_t'(cfg_ch.index))
					agvf_pkg::REG_OMEGA:       omega_q    <= cfg_ch.data[VAL_W-1:0];
					agvf_pkg::REG_ARCH_COEFS:  arch_q     <= cfg_ch.data;
					agvf_pkg::REG_GARCH_COEFS: garch_q    <= cfg_ch.data;
					agvf_pkg::REG_ASYM_SHIFT:  gamma_q    <= cfg_ch.data[VAL_W-1:0];
					agvf_pkg::REG_BACK_CAST:   bc_q       <= cfg_ch.data[VAL_W-1:0];
					agvf_pkg::REG_MODE:        mode_q     <= cfg_ch.data[0];
					agvf_pkg::REG_WARMUP_LEN:  warm_len_q <= cfg_ch.data[agvf_pkg::WARM_W-1:0];
					default: ;
				endcase
			end
		end
	end

	//------------------------------------------------------------------
	// Datapath registers.
	//------------------------------------------------------------------
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;

		if (fin_fire) begin
			out_var_q <= var_q;
			out_sat_q <= flag_q;
		end

		case (state_q)
			agvf_pkg::ST_IDLE: begin
				if (accept) begin
					sample_q <= sample_ch.sample;
					warm_q   <= item_cnt_q < warm_len_q;
					flag_q   <= 1'b0;
					acc_q    <= {{(ACC_W-VAL_W-COEF_W){omega_q[VAL_W-1]}}, omega_q,
						{COEF_W{1'b0}}};
				end
			end
			agvf_pkg::ST_WLO: begin
				g2_q <= prod_q[PROD_W-1:FB];
			end
			agvf_pkg::ST_WHI: begin
				plo_q <= prod_q;
			end
			agvf_pkg::ST_WFIN: begin
				var_q  <= warm_var;
				shk_q  <= warm_shk;
				flag_q <= flag_q | warm_flag;
			end
			agvf_pkg::ST_TAP: begin
				// The product register holds the previous tap's term.
				if (tap_q != '0) acc_q <= acc_q + ACC_W'(prod_q);
			end
			agvf_pkg::ST_VAR: begin
				var_q  <= acc_var;
				flag_q <= flag_q | acc_flag;
				d_q    <= sample_x - {{(D_W-VAL_W){gamma_q[VAL_W-1]}}, gamma_q};
				x_q    <= RAD_W'({acc_var, {FB{1'b0}}});
				root_q <= '0;
				bit_q  <= RAD_W'(1) << (RAD_W - 2);
			end
			agvf_pkg::ST_SQRT: begin
				// One result bit of the integer square root per cycle.
				if ({1'b0, x_q} >= trial) begin
					x_q    <= x_q - trial[RAD_W-1:0];
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			agvf_pkg::ST_DIFF: begin
				// t keeps the sign of gamma, truncated toward zero.
				d_q <= gamma_q[VAL_W-1] ? (sample_x + tx) : (sample_x - tx);
			end
			agvf_pkg::ST_SQUARE: begin
				big_q <= |dmag[D_W-1:MUL_W];
			end
			agvf_pkg::ST_SHOCK: begin
				shk_q  <= sq_shk;
				flag_q <= flag_q | sq_flag;
			end
			default: ;
		endcase
	end

	assign result_ch.valid     = out_valid_q;
	assign result_ch.variance  = out_var_q;
	assign result_ch.saturated = out_sat_q;

endmodule

// File: rtl/core/agvf_checker.sv
// Port-level checks on the variance filter, and the bind that attaches them to the top level.
// Depends on agvf_pkg and the assertion macros header.
`include "asymmetric_garch_variance_filter_unit_macros.svh"

module agvf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [agvf_pkg::VAR_W-1:0]    variance,
	input logic                          saturated,
	input logic                          cfg_valid,
	input logic                          cfg_ready
);

	// A stalled result stays offered and unchanged.
	`AGVF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`AGVF_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(variance) && $stable(saturated))

	// The filter works on one item at a time, so an accepted item closes the input.
	`AGVF_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready)

	// Register writes are never stalled.
	`AGVF_ASSERT_IMPL(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready)

endmodule

bind asymmetric_garch_variance_filter_unit agvf_checker u_agvf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample_ch.valid),
	.in_ready  (sample_ch.ready),
	.out_valid (result_ch.valid),
	.out_ready (result_ch.ready),
	.variance  (result_ch.variance),
	.saturated (result_ch.saturated),
	.cfg_valid (cfg_ch.valid),
	.cfg_ready (cfg_ch.ready)
);
